FILE: sv/gcq_pkg.sv
// ----------------------------------------------------------------------------
// Gregorian calendar query package
// Field widths, calendar constants, pipeline stage types and the small
// calendar tables used by the query pipeline.
// ----------------------------------------------------------------------------
package gcq_pkg;

    // Field widths.
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned MON_W    = 4;
    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned DOY_W    = 9;
    localparam int unsigned SER_W    = 22;
    localparam int unsigned WD_W     = 3;
    localparam int unsigned MASK_W   = 7;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned Q25_W    = 10;
    localparam int unsigned C100_W   = 8;
    localparam int unsigned P4_W     = YEAR_W - 2;
    localparam int unsigned Y365_W   = YEAR_W + DOY_W;
    localparam int unsigned PROD_W   = 2 * YEAR_W;
    localparam int unsigned DSUM_W   = 6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WEEKEND_MASK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEEK_LAST_DAY = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [MASK_W-1:0] WEEKEND_MASK_RST  = 7'd96;
    localparam logic [WD_W-1:0]   WEEK_LAST_DAY_RST = 3'd6;

    // Calendar constants.
    localparam logic [YEAR_W-1:0] YEAR_MAX    = 14'd9999;
    localparam logic [MON_W-1:0]  MON_FEB     = 4'd2;
    localparam logic [MON_W-1:0]  MON_DEC     = 4'd12;
    localparam logic [DOY_W-1:0]  DAYS_YEAR   = 9'd365;
    localparam logic [DOY_W-1:0]  DAYS_LEAP   = 9'd366;
    localparam logic [WD_W-1:0]   DAYS_WEEK   = 3'd7;

    // Division by 25 as a multiply by ceil(2^18 / 25); exact below 43690.
    localparam int unsigned      RECIP_SHIFT = 18;
    localparam logic [YEAR_W-1:0] RECIP_25   = 14'd10486;
    localparam logic [4:0]        FIVE_SQ    = 5'd25;

    typedef struct packed {
        logic [DAY_W-1:0]  d;
        logic [MON_W-1:0]  m;
        logic [YEAR_W-1:0] y;
    } t_date;

    // After the divide-by-25 multipliers.
    typedef struct packed {
        t_date             dt;
        logic [Q25_W-1:0]  q25;
        logic [C100_W-1:0] c100;
    } t_s1;

    // After validity, leap year, day of year and the 365 * (year - 1) term.
    typedef struct packed {
        logic              ok;
        logic              leap;
        logic [DOY_W-1:0]  doy;
        logic [DAY_W-1:0]  dim;
        logic [DAY_W-1:0]  d;
        logic [Y365_W-1:0] y365;
        logic [P4_W-1:0]   p4;
        logic [C100_W-1:0] c100;
    } t_s2;

    // After the serial day numbers.
    typedef struct packed {
        logic              ok;
        logic              inc;
        logic [SER_W-1:0]  s;
        logic [SER_W-1:0]  e;
        logic [DAY_W-1:0]  dtm;
        logic [DOY_W-1:0]  dty;
    } t_s3;

    // After the day difference and the first weekday fold.
    typedef struct packed {
        logic              ok;
        logic [SER_W-1:0]  between;
        logic [DSUM_W-1:0] dsum;
        logic [DAY_W-1:0]  dtm;
        logic [DOY_W-1:0]  dty;
    } t_s4;

    // Days in a month; zero for a month number that means nothing.
    function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] r;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
            4'd2:    r = leap ? 5'd29 : 5'd28;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Days in the year before the first of the month, common year.
    function automatic logic [DOY_W-1:0] month_start(input logic [MON_W-1:0] m);
        logic [DOY_W-1:0] r;
        case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Since 8 is 1 modulo 7, the sum of the octal digits keeps the residue.
    function automatic logic [DSUM_W-1:0] octal_sum(input logic [SER_W-1:0] v);
        logic [SER_W+1:0]  w;
        logic [DSUM_W-1:0] acc;
        w   = {2'b00, v};
        acc = '0;
        for (int k = 0; k < (SER_W + 2) / 3; k++) begin
            acc = acc + DSUM_W'(w[3*k +: 3]);
        end
        return acc;
    endfunction

    // Residue modulo 7 of a digit sum of at most 63.
    function automatic logic [WD_W-1:0] mod7_fold(input logic [DSUM_W-1:0] x);
        logic [3:0] t;
        t = 4'(x[5:3]) + 4'(x[2:0]);
        if (t >= 4'(DAYS_WEEK)) begin
            t = t - 4'(DAYS_WEEK);
        end
        if (t >= 4'(DAYS_WEEK)) begin
            t = t - 4'(DAYS_WEEK);
        end
        return t[WD_W-1:0];
    endfunction

endpackage

FILE: sv/gregorian_calendar_query.sv
// ----------------------------------------------------------------------------
// Gregorian calendar query
// Five-stage pipeline that turns a start date and an end date into the start
// weekday, week, month and year remainders and the day count between them.
// ----------------------------------------------------------------------------
// Usage:
// One input beat carries a start date, an end date and an include-end flag.
// One output beat carries the matching result; beats leave in arrival order.
// Both channels use valid and stall; the receiver of a channel drives stall.
// Throughput is one beat per cycle while the output is not stalled: every
// stage is a register stage with its own valid bit, and a stage loads
// whenever it is empty or the stage after it moves, so bubbles close up
// while the output is stalled. The input stalls only when all five stages
// hold a beat and the output is stalled.
// Each date becomes a serial day number: two divide-by-25 multipliers give
// the century terms, a constant multiply gives 365 * (year - 1), and the
// weekday is the serial number modulo 7, folded over octal digits.
// The configuration port is always ready; write it only while the pipeline
// is empty. Reset empties the pipeline and loads the default weekend mask
// (Friday and Saturday) and last day of week (Saturday).
// When either date is not a real date every output field is zero.
module gregorian_calendar_query
    import gcq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [MASK_W-1:0]     i_cfg_data,
    // Query input channel.
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [DAY_W-1:0]      i_start_day,
    input  logic [MON_W-1:0]      i_start_month,
    input  logic [YEAR_W-1:0]     i_start_year,
    input  logic [DAY_W-1:0]      i_end_day,
    input  logic [MON_W-1:0]      i_end_month,
    input  logic [YEAR_W-1:0]     i_end_year,
    input  logic                  i_include_end,
    // Result output channel.
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_date_valid,
    output logic [WD_W-1:0]       o_week_day,
    output logic                  o_is_end_of_week,
    output logic                  o_is_weekend,
    output logic                  o_is_business_day,
    output logic [WD_W-1:0]       o_days_to_week_end,
    output logic [DAY_W-1:0]      o_days_to_month_end,
    output logic [DOY_W-1:0]      o_days_to_year_end,
    output logic [SER_W-1:0]      o_days_between
);

    localparam int unsigned NSTG = 5;

    // Configuration registers.
    logic [MASK_W-1:0] r_weekend_mask;
    logic [WD_W-1:0]   r_week_last_day;

    // Stage valid bits and load enables.
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_rdy;

    // Stage payloads; index 0 is the start date, index 1 the end date.
    t_s1 r_s1 [2];
    logic r_inc1;
    t_s1 n_s1 [2];
    t_s2 r_s2 [2];
    logic r_inc2;
    t_s2 n_s2 [2];
    t_s3 r_s3;
    t_s3 n_s3;
    t_s4 r_s4;
    t_s4 n_s4;

    // Output registers.
    logic              r_date_valid;
    logic [WD_W-1:0]   r_week_day;
    logic              r_is_end_of_week;
    logic              r_is_weekend;
    logic              r_is_business_day;
    logic [WD_W-1:0]   r_days_to_week_end;
    logic [DAY_W-1:0]  r_days_to_month_end;
    logic [DOY_W-1:0]  r_days_to_year_end;
    logic [SER_W-1:0]  r_days_between;

    logic              n_date_valid;
    logic [WD_W-1:0]   n_week_day;
    logic              n_is_end_of_week;
    logic              n_is_weekend;
    logic              n_is_business_day;
    logic [WD_W-1:0]   n_days_to_week_end;
    logic [DAY_W-1:0]  n_days_to_month_end;
    logic [DOY_W-1:0]  n_days_to_year_end;
    logic [SER_W-1:0]  n_days_between;

    t_date w_in [2];

    assign w_in[0] = '{d: i_start_day, m: i_start_month, y: i_start_year};
    assign w_in[1] = '{d: i_end_day, m: i_end_month, y: i_end_year};

    // A stage loads when it is empty or its content moves on.
    always_comb begin
        w_rdy[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign o_stall     = !w_rdy[0];
    assign o_valid     = r_vld[NSTG-1];
    assign o_cfg_ready = 1'b1;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weekend_mask  <= WEEKEND_MASK_RST;
            r_week_last_day <= WEEK_LAST_DAY_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_WEEKEND_MASK:  r_weekend_mask  <= i_cfg_data;
                REG_WEEK_LAST_DAY: r_week_last_day <= i_cfg_data[WD_W-1:0];
                default: ;
            endcase
        end
    end

    // Valid bits travel with their beats.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 1: year / 25 and (year - 1) / 100 by reciprocal multiplies.
    always_comb begin
        logic [YEAR_W-1:0] p;
        logic [PROD_W-1:0] prod_y;
        logic [PROD_W-1:0] prod_p;
        for (int i = 0; i < 2; i++) begin
            p      = w_in[i].y - YEAR_W'(1);
            prod_y = PROD_W'(w_in[i].y) * PROD_W'(RECIP_25);
            prod_p = PROD_W'(p[YEAR_W-1:2]) * PROD_W'(RECIP_25);
            n_s1[i].dt   = w_in[i];
            n_s1[i].q25  = prod_y[RECIP_SHIFT +: Q25_W];
            n_s1[i].c100 = prod_p[RECIP_SHIFT +: C100_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_s1   <= n_s1;
            r_inc1 <= i_include_end;
        end
    end

    // Stage 2: leap year, date check, day of year and 365 * (year - 1).
    always_comb begin
        logic              z25;
        logic              leap;
        logic [DAY_W-1:0]  dim;
        logic [YEAR_W-1:0] p;
        t_date             dt;
        for (int i = 0; i < 2; i++) begin
            dt   = r_s1[i].dt;
            z25  = ({1'b0, dt.y} == (YEAR_W + 1)'(r_s1[i].q25) * (YEAR_W + 1)'(FIVE_SQ));
            leap = (dt.y[1:0] == 2'b00) && (!z25 || (dt.y[3:0] == 4'b0000));
            dim  = month_days(dt.m, leap);
            p    = dt.y - YEAR_W'(1);
            n_s2[i].ok   = (dt.y != '0) && (dt.y <= YEAR_MAX) && (dt.m != '0)
                           && (dt.m <= MON_DEC) && (dt.d != '0) && (dt.d <= dim);
            n_s2[i].leap = leap;
            n_s2[i].doy  = month_start(dt.m) + DOY_W'(dt.d)
                           + DOY_W'(leap && (dt.m > MON_FEB));
            n_s2[i].dim  = dim;
            n_s2[i].d    = dt.d;
            n_s2[i].y365 = Y365_W'(p) * Y365_W'(DAYS_YEAR);
            n_s2[i].p4   = p[YEAR_W-1:2];
            n_s2[i].c100 = r_s1[i].c100;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_s2   <= n_s2;
            r_inc2 <= r_inc1;
        end
    end

    // Stage 3: serial day numbers and the month and year remainders.
    always_comb begin
        logic [SER_W-1:0] ser [2];
        logic [DOY_W-1:0] ylen;
        for (int i = 0; i < 2; i++) begin
            ser[i] = SER_W'(r_s2[i].y365) + SER_W'(r_s2[i].p4) - SER_W'(r_s2[i].c100)
                     + SER_W'(r_s2[i].c100[C100_W-1:2]) + SER_W'(r_s2[i].doy);
        end
        ylen      = r_s2[0].leap ? DAYS_LEAP : DAYS_YEAR;
        n_s3.ok   = r_s2[0].ok && r_s2[1].ok;
        n_s3.inc  = r_inc2;
        n_s3.s    = ser[0];
        n_s3.e    = ser[1];
        n_s3.dtm  = r_s2[0].dim - r_s2[0].d + DAY_W'(1);
        n_s3.dty  = ylen - r_s2[0].doy + DOY_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_s3 <= n_s3;
        end
    end

    // Stage 4: day difference and the octal digit sum of the start number.
    always_comb begin
        logic [SER_W-1:0] diff;
        diff         = (r_s3.s < r_s3.e) ? (r_s3.e - r_s3.s) : '0;
        n_s4.ok      = r_s3.ok;
        n_s4.between = diff + SER_W'(r_s3.inc);
        n_s4.dsum    = octal_sum(r_s3.s);
        n_s4.dtm     = r_s3.dtm;
        n_s4.dty     = r_s3.dty;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r_s4 <= n_s4;
        end
    end

    // Stage 5: weekday, week flags and zeroing of invalid queries.
    always_comb begin
        logic [WD_W-1:0] wd;
        logic            wend;
        logic [WD_W-1:0] to_week;
        wd   = mod7_fold(r_s4.dsum);
        wend = r_weekend_mask[wd];
        if (r_week_last_day == DAYS_WEEK) begin
            to_week = '0;
        end else if (r_week_last_day >= wd) begin
            to_week = r_week_last_day - wd;
        end else begin
            to_week = r_week_last_day + DAYS_WEEK - wd;
        end
        n_date_valid        = r_s4.ok;
        n_week_day          = r_s4.ok ? wd : '0;
        n_is_end_of_week    = r_s4.ok && (wd == r_week_last_day);
        n_is_weekend        = r_s4.ok && wend;
        n_is_business_day   = r_s4.ok && !wend;
        n_days_to_week_end  = r_s4.ok ? to_week : '0;
        n_days_to_month_end = r_s4.ok ? r_s4.dtm : '0;
        n_days_to_year_end  = r_s4.ok ? r_s4.dty : '0;
        n_days_between      = r_s4.ok ? r_s4.between : '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r_date_valid        <= n_date_valid;
            r_week_day          <= n_week_day;
            r_is_end_of_week    <= n_is_end_of_week;
            r_is_weekend        <= n_is_weekend;
            r_is_business_day   <= n_is_business_day;
            r_days_to_week_end  <= n_days_to_week_end;
            r_days_to_month_end <= n_days_to_month_end;
            r_days_to_year_end  <= n_days_to_year_end;
            r_days_between      <= n_days_between;
        end
    end

    assign o_date_valid        = r_date_valid;
    assign o_week_day          = r_week_day;
    assign o_is_end_of_week    = r_is_end_of_week;
    assign o_is_weekend        = r_is_weekend;
    assign o_is_business_day   = r_is_business_day;
    assign o_days_to_week_end  = r_days_to_week_end;
    assign o_days_to_month_end = r_days_to_month_end;
    assign o_days_to_year_end  = r_days_to_year_end;
    assign o_days_between      = r_days_between;

    // An invalid query leaves every result field at zero.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_date_valid) |-> (o_week_day == '0 && o_days_between == '0
            && o_days_to_month_end == '0 && o_days_to_year_end == '0
            && !o_is_weekend && !o_is_business_day && !o_is_end_of_week))
        else $error("invalid query with nonzero result fields");

    // A valid query is a weekend day or a business day, never both.
    a_day_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_date_valid) |-> (o_is_weekend != o_is_business_day))
        else $error("weekend and business-day flags disagree");

    // A valid query has a real weekday and at least one day left in month and year.
    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_date_valid) |-> (o_week_day < DAYS_WEEK
            && o_days_to_month_end != '0 && o_days_to_year_end != '0))
        else $error("weekday or remainder out of range");

    // With a real last day of week, zero days left means the week ends today.
    a_week_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_date_valid && r_week_last_day != DAYS_WEEK)
            |-> ((o_days_to_week_end == '0) == o_is_end_of_week))
        else $error("end-of-week flag and days to week end disagree");

    // The input stalls only when every stage holds a beat.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_vld == '1 && i_stall))
        else $error("input stalled while the pipeline has room");

endmodule

FILE: bench/gregorian_calendar_query_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian calendar query testbench
// Drives date pairs into the query pipeline with random gaps on the input and
// random stalls on the output. Each result beat is checked field by field
// against a typed answer or the predictor in this file. The run walks a short
// table of corner dates, then random date pairs under several register settings.
// One long output hold-off fills the pipeline so that it stalls its input.
// ----------------------------------------------------------------------------
module gregorian_calendar_query_test;
    import gcq_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 500000;
    localparam int unsigned DRAIN_LIMIT   = 4000;
    localparam int unsigned DRAIN_CYCLES  = 8;
    localparam int unsigned HOLD_CYCLES   = 60;
    localparam int unsigned PHASE_ITEMS   = 200;
    localparam int unsigned BURST_ITEMS   = 60;
    localparam bit          TYPED         = 1'b1;
    localparam bit          PREDICTED     = 1'b0;

    // Indexes past the register list; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    typedef struct packed {
        t_date start_date;
        t_date end_date;
        logic  include_end;
    } t_query;

    typedef struct packed {
        logic              date_valid;
        logic [WD_W-1:0]   week_day;
        logic              is_end_of_week;
        logic              is_weekend;
        logic              is_business_day;
        logic [WD_W-1:0]   days_to_week_end;
        logic [DAY_W-1:0]  days_to_month_end;
        logic [DOY_W-1:0]  days_to_year_end;
        logic [SER_W-1:0]  days_between;
    } t_answer;

    typedef struct packed {
        t_query  query;
        logic    typed;
        t_answer answer;
    } t_row;

    // Block ports.
    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [MASK_W-1:0]    i_cfg_data;
    logic                 i_valid;
    logic                 o_stall;
    logic [DAY_W-1:0]     i_start_day;
    logic [MON_W-1:0]     i_start_month;
    logic [YEAR_W-1:0]    i_start_year;
    logic [DAY_W-1:0]     i_end_day;
    logic [MON_W-1:0]     i_end_month;
    logic [YEAR_W-1:0]    i_end_year;
    logic                 i_include_end;
    logic                 o_valid;
    logic                 i_stall;
    logic                 o_date_valid;
    logic [WD_W-1:0]      o_week_day;
    logic                 o_is_end_of_week;
    logic                 o_is_weekend;
    logic                 o_is_business_day;
    logic [WD_W-1:0]      o_days_to_week_end;
    logic [DAY_W-1:0]     o_days_to_month_end;
    logic [DOY_W-1:0]     o_days_to_year_end;
    logic [SER_W-1:0]     o_days_between;

    // Driven query beat and, for table rows, the answer typed beside it.
    t_query  query_drv;
    logic    typed_drv;
    t_answer typed_answer_drv;

    // Register copies used by the predictor.
    logic [MASK_W-1:0] weekend_days;
    logic [WD_W-1:0]   last_week_day;

    t_answer     answers_due[$];
    t_row        corner_rows[$];
    bit          sender_idle;
    bit          receiver_idle;
    bit          hold_req;
    int unsigned failures;
    int unsigned cycle_count;
    int unsigned queries_sent;
    int unsigned real_pairs;
    int unsigned spans_seen;
    int unsigned input_held;
    int unsigned settings_used;

    assign i_start_day   = query_drv.start_date.d;
    assign i_start_month = query_drv.start_date.m;
    assign i_start_year  = query_drv.start_date.y;
    assign i_end_day     = query_drv.end_date.d;
    assign i_end_month   = query_drv.end_date.m;
    assign i_end_year    = query_drv.end_date.y;
    assign i_include_end = query_drv.include_end;

    gregorian_calendar_query dut (.*);

    // Clock, 10 ns period.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Calendar predictor.
    // ------------------------------------------------------------------------
    function automatic bit leap_of(input int unsigned y);
        return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
    endfunction

    function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
        case (m)
            2:             return leap_of(y) ? 29 : 28;
            4, 6, 9, 11:   return 30;
            1, 3, 5, 7, 8, 10, 12: return 31;
            default:       return 0;
        endcase
    endfunction

    function automatic bit real_date(input t_date dt);
        if (dt.y < 1 || dt.y > 9999 || dt.m < 1 || dt.m > 12) begin
            return 1'b0;
        end
        return dt.d >= 1 && dt.d <= month_length(dt.y, dt.m);
    endfunction

    // Day of the year, 1 for January 1.
    function automatic int unsigned ordinal_day(input t_date dt);
        int unsigned n;
        n = dt.d;
        for (int unsigned k = 1; k < dt.m; k++) begin
            n += month_length(dt.y, k);
        end
        return n;
    endfunction

    // Day number counted from January 1 of year 1, which is day 1 and a Monday.
    function automatic int unsigned day_number(input t_date dt);
        int unsigned p;
        p = dt.y - 1;
        return 365 * p + p / 4 - p / 100 + p / 400 + ordinal_day(dt);
    endfunction

    function automatic t_answer predict_answer(input t_query q,
                                               input logic [MASK_W-1:0] mask,
                                               input logic [WD_W-1:0] last);
        t_answer     a;
        int unsigned s;
        int unsigned e;
        int unsigned wd;
        a = '0;
        if (!real_date(q.start_date) || !real_date(q.end_date)) begin
            return a;
        end
        s  = day_number(q.start_date);
        e  = day_number(q.end_date);
        wd = s % 7;
        a.date_valid        = 1'b1;
        a.week_day          = WD_W'(wd);
        a.is_end_of_week    = (wd == int'(last));
        a.is_weekend        = mask[wd];
        a.is_business_day   = !mask[wd];
        // A last day of 7 matches no weekday.
        a.days_to_week_end  = (last < 7) ? WD_W'((int'(last) + 7 - wd) % 7) : '0;
        a.days_to_month_end = DAY_W'(month_length(q.start_date.y, q.start_date.m)
                                     - q.start_date.d + 1);
        a.days_to_year_end  = DOY_W'((leap_of(q.start_date.y) ? 366 : 365)
                                     - ordinal_day(q.start_date) + 1);
        a.days_between      = SER_W'(((s < e) ? e - s : 0) + q.include_end);
        return a;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus builders.
    // ------------------------------------------------------------------------
    function automatic t_query query_of(input int unsigned sd, input int unsigned sm,
                                        input int unsigned sy, input int unsigned ed,
                                        input int unsigned em, input int unsigned ey,
                                        input int unsigned inc);
        t_query q;
        q.start_date.d = DAY_W'(sd);
        q.start_date.m = MON_W'(sm);
        q.start_date.y = YEAR_W'(sy);
        q.end_date.d   = DAY_W'(ed);
        q.end_date.m   = MON_W'(em);
        q.end_date.y   = YEAR_W'(ey);
        q.include_end  = inc[0];
        return q;
    endfunction

    task automatic add_row(input t_query q, input bit typed, input t_answer a);
        t_row r;
        r.query  = q;
        r.typed  = typed;
        r.answer = a;
        corner_rows.push_back(r);
    endtask

    // Years lean toward the ends of the range and the leap year rules.
    function automatic int unsigned pick_year();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(1, 4);
            1:       return $urandom_range(9996, 9999);
            2:       return 100 * $urandom_range(1, 99);
            3:       return 4 * $urandom_range(1, 2499);
            default: return $urandom_range(1, 9999);
        endcase
    endfunction

    function automatic t_date pick_real_date(input int unsigned y);
        t_date       dt;
        int unsigned len;
        dt.y = YEAR_W'(y);
        dt.m = MON_W'($urandom_range(1, 12));
        len  = month_length(y, dt.m);
        case ($urandom_range(0, 9))
            0:       dt.d = 5'd1;
            1:       dt.d = DAY_W'(len);
            default: dt.d = DAY_W'($urandom_range(1, len));
        endcase
        return dt;
    endfunction

    // Breaks one field of a real date.
    function automatic t_date spoil_date(input t_date dt);
        int unsigned len;
        len = month_length(dt.y, dt.m);
        case ($urandom_range(0, 3))
            0: dt.d = '0;
            1: begin
                if (len < 31) begin
                    dt.d = DAY_W'($urandom_range(len + 1, 31));
                end else begin
                    dt.m = MON_W'($urandom_range(13, 15));
                end
            end
            2: dt.m = $urandom_range(0, 1) ? '0 : MON_W'($urandom_range(13, 15));
            default: dt.y = $urandom_range(0, 1) ? '0 : YEAR_W'($urandom_range(10000, 16383));
        endcase
        return dt;
    endfunction

    function automatic t_query random_query();
        t_query      q;
        logic [63:0] raw;
        int          y;
        int unsigned k;
        q.start_date = pick_real_date(pick_year());
        case ($urandom_range(0, 7))
            0: q.end_date = q.start_date;
            1: q.end_date = pick_real_date(q.start_date.y);
            2: begin
                y = int'(q.start_date.y) + $urandom_range(0, 6) - 3;
                y = (y < 1) ? 1 : (y > 9999) ? 9999 : y;
                q.end_date = pick_real_date(y);
            end
            default: q.end_date = pick_real_date(pick_year());
        endcase
        q.include_end = 1'($urandom_range(0, 1));
        k = $urandom_range(0, 99);
        if (k < 5) begin
            // Raw noise over every bit of the beat.
            raw = {$urandom, $urandom};
            q   = raw[$bits(t_query)-1:0];
        end else if (k < 12) begin
            if ($urandom_range(0, 1)) begin
                q.start_date = spoil_date(q.start_date);
            end else begin
                q.end_date = spoil_date(q.end_date);
            end
        end
        return q;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers. Inputs change at the falling edge.
    // ------------------------------------------------------------------------
    task automatic offer(input t_query q, input bit typed, input t_answer a);
        if (sender_idle && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_valid          <= 1'b1;
        query_drv        <= q;
        typed_drv        <= typed;
        typed_answer_drv <= a;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random(input int unsigned n);
        repeat (n) offer(random_query(), PREDICTED, '0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [MASK_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_WEEKEND_MASK:  weekend_days  = value;
            REG_WEEK_LAST_DAY: last_week_day = value[WD_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Stops offering and waits for the pipeline to empty.
    task automatic drain();
        int unsigned waited;
        waited = 0;
        i_valid <= 1'b0;
        while (answers_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (answers_due.size() != 0) begin
            $error("%0d expected results never arrived", answers_due.size());
            failures++;
            answers_due.delete();
        end
    endtask

    // Output side: random stall bursts, plus one long hold-off on request.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_stall <= 1'b0;
            end else if (receiver_idle && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitors. Handshakes are sampled at the rising edge.
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    // Each accepted query beat queues its expected answer.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            answers_due.push_back(typed_drv ? typed_answer_drv
                                  : predict_answer(query_drv, weekend_days, last_week_day));
            queries_sent++;
        end
        if (i_rst_n && i_valid && o_stall) begin
            input_held++;
        end
    end

    // Each accepted result beat is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (answers_due.size() == 0) begin
                $error("result beat with no query waiting");
                failures++;
            end else begin
                want = answers_due.pop_front();
                check_field("date_valid", want.date_valid, o_date_valid);
                check_field("week_day", want.week_day, o_week_day);
                check_field("is_end_of_week", want.is_end_of_week, o_is_end_of_week);
                check_field("is_weekend", want.is_weekend, o_is_weekend);
                check_field("is_business_day", want.is_business_day, o_is_business_day);
                check_field("days_to_week_end", want.days_to_week_end, o_days_to_week_end);
                check_field("days_to_month_end", want.days_to_month_end, o_days_to_month_end);
                check_field("days_to_year_end", want.days_to_year_end, o_days_to_year_end);
                check_field("days_between", want.days_between, o_days_between);
                if (want.date_valid) begin
                    real_pairs++;
                end
                if (want.days_between != 0) begin
                    spans_seen++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n          = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        i_valid          = 1'b0;
        i_stall          = 1'b0;
        query_drv        = '0;
        typed_drv        = 1'b0;
        typed_answer_drv = '0;
        weekend_days     = WEEKEND_MASK_RST;
        last_week_day    = WEEK_LAST_DAY_RST;
        sender_idle      = 1'b1;
        receiver_idle    = 1'b1;
        hold_req         = 1'b0;
        failures         = 0;
        cycle_count      = 0;
        queries_sent     = 0;
        real_pairs       = 0;
        spans_seen       = 0;
        input_held       = 0;
        settings_used    = 1;

        // Corner dates under the reset registers: Friday and Saturday off,
        // Saturday ends the week.
        add_row(query_of(1, 1, 1, 31, 12, 9999, 1), TYPED,
                '{1'b1, 3'd1, 1'b0, 1'b0, 1'b1, 3'd5, 5'd31, 9'd365, 22'd3652059});
        add_row(query_of(31, 12, 9999, 1, 1, 1, 0), TYPED,
                '{1'b1, 3'd5, 1'b0, 1'b1, 1'b0, 3'd1, 5'd1, 9'd1, 22'd0});
        add_row(query_of(31, 12, 9999, 31, 12, 9999, 1), TYPED,
                '{1'b1, 3'd5, 1'b0, 1'b1, 1'b0, 3'd1, 5'd1, 9'd1, 22'd1});
        add_row(query_of(1, 1, 1, 1, 1, 1, 0), TYPED,
                '{1'b1, 3'd1, 1'b0, 1'b0, 1'b1, 3'd5, 5'd31, 9'd365, 22'd0});
        // Dates that do not exist give an all-zero answer.
        add_row(query_of(10, 0, 2020, 1, 1, 2021, 1), TYPED, '0);
        add_row(query_of(10, 5, 2020, 1, 13, 2021, 1), TYPED, '0);
        add_row(query_of(10, 15, 2020, 1, 1, 2021, 0), TYPED, '0);
        add_row(query_of(0, 5, 2020, 1, 1, 2021, 1), TYPED, '0);
        add_row(query_of(31, 4, 2020, 1, 1, 2021, 1), TYPED, '0);
        add_row(query_of(29, 2, 1900, 1, 1, 2021, 1), TYPED, '0);
        add_row(query_of(1, 1, 2000, 30, 2, 2000, 1), TYPED, '0);
        add_row(query_of(1, 1, 0, 1, 1, 2021, 1), TYPED, '0);
        add_row(query_of(1, 1, 2000, 1, 1, 10000, 1), TYPED, '0);
        add_row(query_of(31, 15, 16383, 1, 1, 2021, 1), TYPED, '0);
        add_row(query_of(1, 1, 2000, 31, 6, 2000, 0), TYPED, '0);
        // Leap rules, year ends, start later than end and the week boundary.
        add_row(query_of(29, 2, 2000, 1, 3, 2000, 0), PREDICTED, '0);
        add_row(query_of(29, 2, 2024, 1, 1, 2025, 1), PREDICTED, '0);
        add_row(query_of(28, 2, 1900, 1, 3, 1900, 0), PREDICTED, '0);
        add_row(query_of(31, 12, 2023, 1, 1, 2024, 0), PREDICTED, '0);
        add_row(query_of(2, 3, 2024, 1, 3, 2024, 1), PREDICTED, '0);
        add_row(query_of(3, 3, 2024, 4, 3, 2024, 1), PREDICTED, '0);
        add_row(query_of(1, 3, 2024, 8, 3, 2024, 0), PREDICTED, '0);
        add_row(query_of(15, 10, 1582, 4, 10, 1582, 1), PREDICTED, '0);
        add_row(query_of(28, 2, 2100, 29, 2, 2400, 0), PREDICTED, '0);
        add_row(query_of(29, 2, 4, 31, 12, 100, 1), PREDICTED, '0);

        // Synchronous reset, released at a falling edge.
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (corner_rows[n]) begin
            offer(corner_rows[n].query, corner_rows[n].typed, corner_rows[n].answer);
        end
        send_random(PHASE_ITEMS);
        drain();

        // No weekend, week ends on Sunday. The output holds off while the
        // input keeps offering, so the pipeline fills and stalls its input.
        write_register(REG_WEEKEND_MASK, 7'h00);
        write_register(REG_WEEK_LAST_DAY, 7'h00);
        settings_used++;
        sender_idle = 1'b0;
        hold_req    = 1'b1;
        send_random(BURST_ITEMS);
        sender_idle = 1'b1;
        send_random(PHASE_ITEMS);
        drain();

        // Every day a weekend day; upper data bits of the week register ignored.
        write_register(REG_WEEKEND_MASK, 7'h7F);
        write_register(REG_WEEK_LAST_DAY, 7'h7E);
        settings_used++;
        send_random(PHASE_ITEMS);
        drain();

        // A last day of 7 matches no weekday; writes past the list are dropped.
        write_register(REG_WEEK_LAST_DAY, 7'h7F);
        write_register(REG_WEEKEND_MASK, 7'h55);
        write_register(REG_SPARE_LO, 7'h00);
        write_register(REG_SPARE_HI, 7'h7F);
        settings_used++;
        send_random(PHASE_ITEMS);
        drain();

        write_register(REG_WEEKEND_MASK, MASK_W'($urandom_range(0, 127)));
        write_register(REG_WEEK_LAST_DAY, MASK_W'($urandom_range(0, 7)));
        settings_used++;
        send_random(PHASE_ITEMS);
        drain();

        // Closing stretch at full rate on both sides.
        write_register(REG_WEEKEND_MASK, MASK_W'($urandom_range(0, 127)));
        write_register(REG_WEEK_LAST_DAY, MASK_W'($urandom_range(0, 7)));
        settings_used++;
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        send_random(PHASE_ITEMS);
        drain();

        $display("Ran %0d date queries under %0d register settings: %0d real date pairs, %0d with a nonzero day count.",
                 queries_sent, settings_used, real_pairs, spans_seen);
        $display("The pipeline held back its input on %0d cycles.", input_held);
        if (failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
